// ===== rtl/jps_pkg.sv =====
`default_nettype none
package jps_pkg;

  localparam int unsigned PACKET_BYTES = 16;
  localparam int unsigned PKT_BITS     = PACKET_BYTES * 8;
  localparam int unsigned STORE_AW     = $clog2(PKT_BITS);

  localparam logic signed [8:0] BP_IDLE = -9'sd1;
  localparam logic signed [8:0] BP_FULL = 9'sd128;
  localparam logic signed [8:0] BP_SENT = 9'sd129;
  localparam logic signed [8:0] BP_HSK  = 9'sd135;

  localparam logic [7:0] SEL_FORCE = 8'hCF;
  localparam logic [7:0] SEL_LOW   = 8'h0F;

  typedef enum logic [1:0] {
    REQ_WRITE  = 2'd0,
    REQ_READ   = 2'd1,
    REQ_RESCAN = 2'd2,
    REQ_NONE   = 2'd3
  } req_e;

  typedef enum logic [1:0] {
    CFG_PKT_EN   = 2'd0,
    CFG_CTL_MASK = 2'd1,
    CFG_ALLOW_OP = 2'd2,
    CFG_UNUSED   = 2'd3
  } cfg_e;

  typedef enum logic [1:0] {
    SEL_BOTH = 2'b00,
    SEL_BTN  = 2'b01,
    SEL_DIR  = 2'b10,
    SEL_ID   = 2'b11
  } sel_e;

  typedef enum logic [1:0] {
    LC_RESET = 2'd0,
    LC_ONE   = 2'd1,
    LC_SEND  = 2'd2,
    LC_STEP  = 2'd3
  } lc_e;

  typedef struct packed {
    logic [1:0] req_type;
    logic [7:0] write_value;
    logic [7:0] pad_keys;
  } in_t;

  typedef struct packed {
    logic        out_kind;
    logic [7:0]  joyp_value;
    logic        keypad_irq;
    logic [63:0] packet_word;
    logic        is_last;
  } out_t;

  typedef struct packed {
    logic [7:0]          joyp;
    logic                irq;
    logic                sent;
    logic [PKT_BITS-1:0] pkt;
  } grp_t;

endpackage
`default_nettype wire

// ===== rtl/joypad_scan_with_packet_receiver.sv =====
// channel | ports                          | accepted when
// in      | in_valid, in_ready, in_data    | in_valid & in_ready
// out     | out_valid, out_ready, out_data | out_valid & out_ready
// cfg     | cfg_valid, cfg_ready, cfg_index, cfg_data | cfg_valid & cfg_ready
//
// One request per cycle is taken while in_ready is high; state updates at the
// accept edge. Results leave from a two-group queue: one beat per request,
// three when a packet goes out, so throughput is set by the output beats.
// in_ready drops only while both queue slots are held by undelivered results.
// Synchronous active-low reset; cfg_ready is always high.
`default_nettype none
module joypad_scan_with_packet_receiver
  import jps_pkg::*;
(
  input  wire logic       clk,
  input  wire logic       rst_n,
  input  wire logic       in_valid,
  output logic            in_ready,
  input  wire in_t        in_data,
  output logic            out_valid,
  input  wire logic       out_ready,
  output out_t            out_data,
  input  wire logic       cfg_valid,
  output logic            cfg_ready,
  input  wire logic [1:0] cfg_index,
  input  wire logic [1:0] cfg_data
);

  logic in_acc;
  grp_t grp;

  assign cfg_ready = 1'b1;
  assign in_acc    = in_valid && in_ready;

  jps_core u_core (
    .clk       (clk),
    .rst_n     (rst_n),
    .cfg_we    (cfg_valid),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .req_we    (in_acc),
    .req       (in_data),
    .grp       (grp)
  );

  jps_outq u_outq (
    .clk       (clk),
    .rst_n     (rst_n),
    .push      (in_acc),
    .push_grp  (grp),
    .can_push  (in_ready),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .out_data  (out_data)
  );

endmodule
`default_nettype wire

// ===== rtl/jps_core.sv =====
`default_nettype none
module jps_core
  import jps_pkg::*;
(
  input  wire logic       clk,
  input  wire logic       rst_n,
  input  wire logic       cfg_we,
  input  wire logic [1:0] cfg_index,
  input  wire logic [1:0] cfg_data,
  input  wire logic       req_we,
  input  wire in_t        req,
  output grp_t            grp
);

  logic                pkt_en_r;
  logic [1:0]          ctl_mask_r;
  logic                allow_op_r;
  logic [7:0]          sel_r,   sel_nxt;
  logic signed [8:0]   bp_r,    bp_nxt;
  logic [1:0]          last_r,  last_nxt;
  logic [PKT_BITS-1:0] store_r, store_nxt;
  logic [1:0]          cidx_r,  cidx_nxt;

  always_comb begin
    logic [7:0]        old;
    logic [7:0]        keys;
    logic [3:0]        k;
    logic [7:0]        scanned;
    logic [7:0]        joyp;
    logic              irq;
    logic              sent;
    logic [1:0]        c;
    logic signed [8:0] bp;
    old       = (req.req_type == REQ_WRITE) ? (req.write_value | SEL_LOW) : sel_r;
    keys      = (cidx_r != 2'd0) ? 8'd0 : req.pad_keys;
    k         = 4'd0;
    sent      = 1'b0;
    c         = req.write_value[5:4];
    bp        = bp_r;
    sel_nxt   = sel_r;
    bp_nxt    = bp_r;
    last_nxt  = last_r;
    store_nxt = store_r;
    cidx_nxt  = cidx_r;
    unique case (sel_e'(old[5:4]))
      SEL_ID:   k = {2'b00, cidx_r};
      SEL_DIR:  k = keys[7:4];
      SEL_BTN:  k = keys[3:0];
      SEL_BOTH: k = keys[3:0] | keys[7:4];
      default:  k = 4'd0;
    endcase
    scanned = (SEL_FORCE | old) ^ {4'd0, k};
    irq     = |(old[3:0] & ~scanned[3:0]);
    joyp    = scanned;
    if (req.req_type == REQ_NONE) begin
      irq  = 1'b0;
      joyp = sel_r;
    end else begin
      sel_nxt = scanned;
    end
    if (req.req_type == REQ_READ && !allow_op_r && scanned[5:4] == SEL_DIR) begin
      if (scanned[1:0] == 2'b00) joyp[1:0] = 2'b11;
      if (scanned[3:2] == 2'b00) joyp[3:2] = 2'b11;
    end
    if (req.req_type == REQ_WRITE && pkt_en_r) begin
      if (c == LC_RESET) begin
        bp        = BP_IDLE;
        store_nxt = '0;
      end
      if (c != last_r) begin
        last_nxt = c;
        if (bp > BP_FULL) begin
          if (c == LC_ONE) begin
            bp = bp | 9'sd2;
          end else if (c == LC_SEND) begin
            bp = bp | 9'sd4;
          end else if (c == LC_STEP && bp == BP_HSK) begin
            bp       = bp & ~9'sd6;
            cidx_nxt = (cidx_r + 2'd1) & ctl_mask_r;
          end
        end
        if (bp == BP_FULL && c == LC_SEND) begin
          sent = 1'b1;
          bp   = BP_SENT;
        end
        if (bp < BP_FULL) begin
          if (c == LC_ONE && bp >= 9'sd0) begin
            store_nxt[bp[STORE_AW-1:0]] = 1'b1;
          end else if (c == LC_STEP) begin
            bp = bp + 9'sd1;
          end
        end
      end
      bp_nxt = bp;
    end
    grp.joyp = joyp;
    grp.irq  = irq;
    grp.sent = sent;
    grp.pkt  = store_nxt;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      pkt_en_r   <= 1'b1;
      ctl_mask_r <= 2'd0;
      allow_op_r <= 1'b0;
      sel_r      <= 8'hFF;
      bp_r       <= BP_IDLE;
      last_r     <= 2'd0;
      store_r    <= '0;
      cidx_r     <= 2'd0;
    end else begin
      if (cfg_we) begin
        unique case (cfg_e'(cfg_index))
          CFG_PKT_EN:   pkt_en_r   <= cfg_data[0];
          CFG_CTL_MASK: ctl_mask_r <= cfg_data;
          CFG_ALLOW_OP: allow_op_r <= cfg_data[0];
          default:      ;
        endcase
      end
      if (req_we) begin
        sel_r   <= sel_nxt;
        bp_r    <= bp_nxt;
        last_r  <= last_nxt;
        store_r <= store_nxt;
        cidx_r  <= cidx_nxt;
      end
    end
  end

endmodule
`default_nettype wire

// ===== rtl/jps_outq.sv =====
`default_nettype none
module jps_outq
  import jps_pkg::*;
(
  input  wire logic clk,
  input  wire logic rst_n,
  input  wire logic push,
  input  wire grp_t push_grp,
  output logic      can_push,
  output logic      out_valid,
  input  wire logic out_ready,
  output out_t      out_data
);

  grp_t       slot_r [2];
  logic       wr_ptr_r, rd_ptr_r;
  logic [1:0] count_r;
  logic [1:0] beat_r;
  grp_t       cur;
  logic       pop;

  assign cur       = slot_r[rd_ptr_r];
  assign can_push  = (count_r != 2'd2);
  assign out_valid = (count_r != 2'd0);

  always_comb begin
    out_data.out_kind   = (beat_r != 2'd0);
    out_data.joyp_value = cur.joyp;
    out_data.keypad_irq = cur.irq;
    out_data.is_last    = !cur.sent || (beat_r == 2'd2);
    unique case (beat_r)
      2'd1:    out_data.packet_word = cur.pkt[63:0];
      2'd2:    out_data.packet_word = cur.pkt[PKT_BITS-1:64];
      default: out_data.packet_word = 64'd0;
    endcase
  end

  assign pop = out_valid && out_ready && out_data.is_last;

  always_ff @(posedge clk) begin
    if (push) begin
      slot_r[wr_ptr_r] <= push_grp;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= 1'b0;
      rd_ptr_r <= 1'b0;
      count_r  <= 2'd0;
      beat_r   <= 2'd0;
    end else begin
      if (push) wr_ptr_r <= !wr_ptr_r;
      if (pop) rd_ptr_r <= !rd_ptr_r;
      count_r <= count_r + {1'b0, push} - {1'b0, pop};
      if (out_valid && out_ready) begin
        beat_r <= pop ? 2'd0 : beat_r + 2'd1;
      end
    end
  end

`ifndef SYNTH
  a_beat_needs_packet: assert property (@(posedge clk) disable iff (!rst_n)
    (beat_r != 2'd0) |-> (out_valid && cur.sent))
    else $error("packet beat without a sent packet");
  a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
    count_r != 2'd3)
    else $error("result queue overflow");
  a_group_continues: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && out_ready && !out_data.is_last) |=> (out_valid && beat_r != 2'd0))
    else $error("packet group broken");
  a_no_push_full: assert property (@(posedge clk) disable iff (!rst_n)
    push |-> can_push)
    else $error("push into full queue");
`endif

endmodule
`default_nettype wire
